@@ src/sha1_pkg.sv @@
// SHA-1 package: constants, state type, work-register struct and round helpers.
`default_nettype none

package sha1_pkg;

    localparam int unsigned WordW    = 32;
    localparam int unsigned BlkWords = 16;
    localparam int unsigned HashN    = 5;

    typedef logic [WordW-1:0] t_word;

    localparam t_word H0 = 32'h67452301;
    localparam t_word H1 = 32'hEFCDAB89;
    localparam t_word H2 = 32'h98BADCFE;
    localparam t_word H3 = 32'h10325476;
    localparam t_word H4 = 32'hC3D2E1F0;

    localparam t_word K0 = 32'h5A827999;
    localparam t_word K1 = 32'h6ED9EBA1;
    localparam t_word K2 = 32'h8F1BBCDC;
    localparam t_word K3 = 32'hCA62C1D6;

    localparam logic [7:0] PAD_BYTE = 8'h80;

    // Round boundaries
    localparam logic [6:0] RND_SCHED = 7'd16;
    localparam logic [6:0] RND_F1    = 7'd20;
    localparam logic [6:0] RND_F2    = 7'd40;
    localparam logic [6:0] RND_F3    = 7'd60;
    localparam logic [6:0] RND_LAST  = 7'd79;

    localparam logic [2:0] IDX_LAST  = 3'd4;
    localparam logic [5:0] POS_LAST  = 6'd63;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PAD,
        ST_ROUND,
        ST_ADD,
        ST_OUT
    } t_state;

    typedef struct packed {
        t_word a;
        t_word b;
        t_word c;
        t_word d;
        t_word e;
    } t_work;

    function automatic t_word rotl1(input t_word v);
        return {v[WordW-2:0], v[WordW-1]};
    endfunction

    function automatic t_word rotl5(input t_word v);
        return {v[WordW-6:0], v[WordW-1:WordW-5]};
    endfunction

    function automatic t_word rotl30(input t_word v);
        return {v[1:0], v[WordW-1:2]};
    endfunction

    function automatic t_word sha1_f(input logic [6:0] rnd, input t_word b,
                                     input t_word c, input t_word d);
        t_word f;
        if (rnd < RND_F1) begin
            f = (b & c) | (~b & d);
        end else if (rnd < RND_F2) begin
            f = b ^ c ^ d;
        end else if (rnd < RND_F3) begin
            f = (b & c) | (b & d) | (c & d);
        end else begin
            f = b ^ c ^ d;
        end
        return f;
    endfunction

    function automatic t_word sha1_k(input logic [6:0] rnd);
        t_word k;
        if (rnd < RND_F1) begin
            k = K0;
        end else if (rnd < RND_F2) begin
            k = K1;
        end else if (rnd < RND_F3) begin
            k = K2;
        end else begin
            k = K3;
        end
        return k;
    endfunction

endpackage

`default_nettype wire

@@ src/sha1_message_digest_core.sv @@
// SHA-1 message digest core: byte stream in, five digest words out.
`default_nettype none

// Channel   Direction  Handshake            Payload
// -------   ---------  -------------------  -----------------------------------------
// input     in         i_valid / o_ready    i_byte_value, i_byte_present, i_is_last
// output    out        o_valid / i_ready    o_digest_word, o_word_index, o_last_word
//
// A byte request that neither fills the block nor is last leaves the core idle, o_ready high.
// A byte that fills the 64-byte block starts a compression: 80 rounds through the single
// shared round unit, one per cycle, then the hash add into h0..h4.
// A last request then feeds padding and length bytes one per cycle up to the block end,
// compresses (once or twice), and presents h0..h4 one word per accepted transfer.
// Reset (i_rst_n low, synchronous) loads the initial hash and clears count and control.
// A stalled output holds its word; no input is taken until the fifth word is accepted.

module sha1_message_digest_core (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_valid,
    output logic                       o_ready,
    input  wire logic [7:0]            i_byte_value,
    input  wire logic                  i_byte_present,
    input  wire logic                  i_is_last,
    output logic                       o_valid,
    input  wire logic                  i_ready,
    output sha1_pkg::t_word            o_digest_word,
    output logic [2:0]                 o_word_index,
    output logic                       o_last_word
);
    import sha1_pkg::*;

    t_state        r_state, n_state;
    t_word         r_h   [HashN];
    t_word         r_blk [BlkWords];   // shift line, r_blk[0] is the oldest word
    logic [23:0]   r_acc;              // bytes of the word being packed
    logic [5:0]    r_pos;              // byte position in block
    logic [60:0]   r_cnt;              // message bytes, wraps at 2^61
    logic [63:0]   r_len;              // bit length, MSB byte first
    t_work         r_work;
    logic [6:0]    r_round;
    logic          r_first;            // next pad byte is the 0x80 marker
    logic          r_wrap;             // marker landed in the length slot
    logic          r_next_pad;
    logic          r_final;
    logic [2:0]    r_idx;

    logic          in_acc, out_acc;
    logic          byte_we;
    logic [7:0]    byte_val;
    logic          pad_len;
    logic [60:0]   cnt_nx;
    t_work         rnd_work;
    t_word         rnd_wr;

    assign in_acc  = i_valid && o_ready;
    assign out_acc = o_valid && i_ready;
    assign cnt_nx  = r_cnt + {60'd0, i_byte_present};

    // Length bytes go to positions 56..63 of the block that has room for them
    assign pad_len = !r_first && (r_pos[5:3] == 3'b111) && !r_wrap;

    sha1_round u_round (
        .i_work  (r_work),
        .i_round (r_round),
        .i_w0    (r_blk[0]),
        .i_w2    (r_blk[2]),
        .i_w8    (r_blk[8]),
        .i_w13   (r_blk[13]),
        .o_work  (rnd_work),
        .o_wr    (rnd_wr)
    );

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    if (i_byte_present && (r_pos == POS_LAST)) begin
                        n_state = ST_ROUND;
                    end else if (i_is_last) begin
                        n_state = ST_PAD;
                    end
                end
            end
            ST_PAD: begin
                if (r_pos == POS_LAST) begin
                    n_state = ST_ROUND;
                end
            end
            ST_ROUND: begin
                if (r_round == RND_LAST) begin
                    n_state = ST_ADD;
                end
            end
            ST_ADD: begin
                if (r_final) begin
                    n_state = ST_OUT;
                end else if (r_next_pad) begin
                    n_state = ST_PAD;
                end else begin
                    n_state = ST_IDLE;
                end
            end
            ST_OUT: begin
                if (out_acc && (r_idx == IDX_LAST)) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // State-driven outputs and byte source
    always_comb begin
        o_ready  = 1'b0;
        o_valid  = 1'b0;
        byte_we  = 1'b0;
        byte_val = i_byte_value;
        case (r_state)
            ST_IDLE: begin
                o_ready = 1'b1;
                byte_we = in_acc && i_byte_present;
            end
            ST_PAD: begin
                byte_we = 1'b1;
                if (r_first) begin
                    byte_val = PAD_BYTE;
                end else if (pad_len) begin
                    byte_val = r_len[63:56];
                end else begin
                    byte_val = 8'd0;
                end
            end
            ST_OUT: begin
                o_valid = 1'b1;
            end
            default: begin
                o_ready = 1'b0;
            end
        endcase
    end

    always_comb begin
        case (r_idx)
            3'd0:    o_digest_word = r_h[0];
            3'd1:    o_digest_word = r_h[1];
            3'd2:    o_digest_word = r_h[2];
            3'd3:    o_digest_word = r_h[3];
            default: o_digest_word = r_h[4];
        endcase
    end

    assign o_word_index = r_idx;
    assign o_last_word  = (r_idx == IDX_LAST);

    // Block shift line: packed message words in, schedule words during rounds
    always_ff @(posedge i_clk) begin
        if (r_state == ST_ROUND) begin
            for (int i = 0; i < BlkWords - 1; i++) begin
                r_blk[i] <= r_blk[i+1];
            end
            r_blk[BlkWords-1] <= rnd_wr;
        end else if (byte_we && (r_pos[1:0] == 2'b11)) begin
            for (int i = 0; i < BlkWords - 1; i++) begin
                r_blk[i] <= r_blk[i+1];
            end
            r_blk[BlkWords-1] <= {r_acc, byte_val};
        end
        if (byte_we) begin
            r_acc <= {r_acc[15:0], byte_val};
        end
        if (r_state == ST_ROUND) begin
            r_work  <= rnd_work;
            r_round <= r_round + 7'd1;
        end else begin
            r_work  <= '{a: r_h[0], b: r_h[1], c: r_h[2], d: r_h[3], e: r_h[4]};
            r_round <= 7'd0;
        end
        if (in_acc && i_is_last) begin
            r_len <= {cnt_nx, 3'b000};
        end else if ((r_state == ST_PAD) && pad_len) begin
            r_len <= {r_len[55:0], 8'd0};
        end
    end

    // Control and hash state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_h[0]     <= H0;
            r_h[1]     <= H1;
            r_h[2]     <= H2;
            r_h[3]     <= H3;
            r_h[4]     <= H4;
            r_pos      <= 6'd0;
            r_cnt      <= 61'd0;
            r_first    <= 1'b0;
            r_wrap     <= 1'b0;
            r_next_pad <= 1'b0;
            r_final    <= 1'b0;
            r_idx      <= 3'd0;
        end else begin
            r_state <= n_state;
            if (byte_we) begin
                r_pos <= r_pos + 6'd1;
            end
            if (in_acc) begin
                r_cnt      <= cnt_nx;
                r_next_pad <= i_is_last;
                r_final    <= 1'b0;
                r_first    <= i_is_last;
                r_wrap     <= 1'b0;
            end
            if (r_state == ST_PAD) begin
                r_first <= 1'b0;
                if (r_pos == POS_LAST) begin
                    r_final <= !(r_first || r_wrap);
                    r_wrap  <= 1'b0;
                end else if (r_first) begin
                    r_wrap <= (r_pos[5:3] == 3'b111);
                end
            end
            if (r_state == ST_ADD) begin
                r_h[0] <= r_h[0] + r_work.a;
                r_h[1] <= r_h[1] + r_work.b;
                r_h[2] <= r_h[2] + r_work.c;
                r_h[3] <= r_h[3] + r_work.d;
                r_h[4] <= r_h[4] + r_work.e;
            end
            if (out_acc) begin
                if (r_idx == IDX_LAST) begin
                    r_idx      <= 3'd0;
                    r_h[0]     <= H0;
                    r_h[1]     <= H1;
                    r_h[2]     <= H2;
                    r_h[3]     <= H3;
                    r_h[4]     <= H4;
                    r_cnt      <= 61'd0;
                    r_next_pad <= 1'b0;
                    r_final    <= 1'b0;
                end else begin
                    r_idx <= r_idx + 3'd1;
                end
            end
        end
    end

endmodule

`default_nettype wire

@@ src/sha1_round.sv @@
// SHA-1 round datapath: schedule word and one round of the a..e update.
`default_nettype none

module sha1_round (
    input  sha1_pkg::t_work    i_work,
    input  logic [6:0]         i_round,
    input  sha1_pkg::t_word    i_w0,
    input  sha1_pkg::t_word    i_w2,
    input  sha1_pkg::t_word    i_w8,
    input  sha1_pkg::t_word    i_w13,
    output sha1_pkg::t_work    o_work,
    output sha1_pkg::t_word    o_wr
);
    import sha1_pkg::*;

    t_word wr;
    t_word t;

    // First 16 rounds take the block words as they are
    assign wr = (i_round < RND_SCHED) ? i_w0 : rotl1(i_w13 ^ i_w8 ^ i_w2 ^ i_w0);

    assign t = rotl5(i_work.a) + sha1_f(i_round, i_work.b, i_work.c, i_work.d)
             + i_work.e + sha1_k(i_round) + wr;

    assign o_work = '{a: t, b: i_work.a, c: rotl30(i_work.b), d: i_work.c, e: i_work.d};
    assign o_wr   = wr;

endmodule

`default_nettype wire

@@ src/sha1_chk.sv @@
// Port-level checker for the SHA-1 core, bound to the top level.
`default_nettype none

module sha1_chk (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        o_ready,
    input wire logic        o_valid,
    input wire logic        i_ready,
    input wire logic [31:0] o_digest_word,
    input wire logic [2:0]  o_word_index,
    input wire logic        o_last_word
);

    // A stalled digest word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_digest_word)
                                && $stable(o_word_index))
        else $error("digest word changed while stalled");

    // No new request is taken while digest words are pending
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_valid && o_ready))
        else $error("input ready while digest pending");

    // Last flag marks exactly the fifth word
    a_last_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_last_word == (o_word_index == 3'd4)))
        else $error("last flag mismatch");

    // Words come in order without gaps
    a_word_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_ready && !o_last_word |=>
            o_valid && (o_word_index == $past(o_word_index) + 3'd1))
        else $error("digest word order broken");

    // A run of digest words starts at h0
    a_first_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> (o_word_index == 3'd0))
        else $error("digest run does not start at word 0");

endmodule

bind sha1_message_digest_core sha1_chk u_sha1_chk (.*);

`default_nettype wire

@@ sim/tb_top.sv @@
// Testbench for the SHA-1 digest core: byte requests in, digest words checked against a local model.
`timescale 1ns / 100ps

module tb_top;
    import sha1_pkg::*;

    // Cycles with no transfer on either side before the run is declared hung.
    // The slowest legal gap is a final byte followed by padding, two compressions
    // and a receiver stall.
    localparam int unsigned IdleLimit   = 4000;
    // Quiet time after the last digest word, to catch stray output words.
    localparam int unsigned DrainCycles = 300;

    typedef struct {
        logic [7:0] value;
        logic       present;
        logic       last;
        logic       wait_drain;   // hold this request until all digests are out
    } t_byte_request;

    typedef struct {
        t_word      word;
        logic [2:0] index;
        logic       last;
    } t_digest_beat;

    // DUT ports
    logic       i_clk          = 1'b0;
    logic       i_rst_n        = 1'b0;
    logic       i_valid        = 1'b0;
    logic       o_ready;
    logic [7:0] i_byte_value   = 8'h00;
    logic       i_byte_present = 1'b0;
    logic       i_is_last      = 1'b0;
    logic       o_valid;
    logic       i_ready        = 1'b0;
    t_word      o_digest_word;
    logic [2:0] o_word_index;
    logic       o_last_word;

    // Request stream and expected digest words
    t_byte_request byte_requests[$];
    t_digest_beat  pending_digest_words[$];
    t_digest_beat  want;

    // Local SHA-1 state, advanced on every accepted request
    t_word       run_hash[5];
    t_word       msg_block[16];
    logic [60:0] msg_len_bytes;

    // Sender burst shaping and receiver stall pattern
    int unsigned burst_left   = 0;
    int unsigned gap_left     = 0;
    logic [7:0]  ready_bits   = 8'hFF;
    int unsigned ready_phase  = 0;

    int unsigned mismatches   = 0;
    int unsigned idle_cycles  = 0;
    int unsigned queued_items = 0;
    int unsigned messages     = 0;
    int unsigned pick;

    sha1_message_digest_core dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_byte_value   (i_byte_value),
        .i_byte_present (i_byte_present),
        .i_is_last      (i_is_last),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_digest_word  (o_digest_word),
        .o_word_index   (o_word_index),
        .o_last_word    (o_last_word)
    );

    always #5 i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // SHA-1 prediction
    // ------------------------------------------------------------------
    function automatic t_word rotate_left(input t_word v, input int unsigned n);
        return (v << n) | (v >> (WordW - n));
    endfunction

    function automatic void reload_initial_hash();
        run_hash = '{H0, H1, H2, H3, H4};
    endfunction

    // One 80-round compression of msg_block into run_hash.
    function automatic void compress_block_words();
        t_word sched[16];
        t_word a, b, c, d, e, f, k, wr, tmp;
        sched = msg_block;
        a = run_hash[0];
        b = run_hash[1];
        c = run_hash[2];
        d = run_hash[3];
        e = run_hash[4];
        for (int r = 0; r < 80; r++) begin
            if (r < 16) begin
                wr = sched[r];
            end else begin
                // rolling 16-word schedule window
                wr = rotate_left(sched[(r + 13) & 15] ^ sched[(r + 8) & 15] ^
                                 sched[(r + 2) & 15] ^ sched[r & 15], 1);
                sched[r & 15] = wr;
            end
            if (r < 20) begin
                f = (b & c) | (~b & d);
                k = K0;
            end else if (r < 40) begin
                f = b ^ c ^ d;
                k = K1;
            end else if (r < 60) begin
                f = (b & c) | (b & d) | (c & d);
                k = K2;
            end else begin
                f = b ^ c ^ d;
                k = K3;
            end
            tmp = rotate_left(a, 5) + f + e + k + wr;
            e = d;
            d = c;
            c = rotate_left(b, 30);
            b = a;
            a = tmp;
        end
        run_hash[0] = run_hash[0] + a;
        run_hash[1] = run_hash[1] + b;
        run_hash[2] = run_hash[2] + c;
        run_hash[3] = run_hash[3] + d;
        run_hash[4] = run_hash[4] + e;
    endfunction

    // Big-endian byte placement; the first byte of a word clears the rest of it.
    function automatic void place_byte(input logic [5:0] pos, input logic [7:0] b);
        if (pos[1:0] == 2'd0) begin
            msg_block[pos[5:2]] = {b, 24'h000000};
        end else begin
            msg_block[pos[5:2]] = msg_block[pos[5:2]] |
                                  (t_word'(b) << ((3 - pos[1:0]) * 8));
        end
    endfunction

    // Advance the local hash by one accepted request; a last request queues
    // the five digest words it must produce.
    function automatic void predict_request(input logic [7:0] b, input logic present,
                                            input logic last);
        logic [5:0]  pos;
        logic [63:0] bit_len;
        if (present) begin
            pos = msg_len_bytes[5:0];
            place_byte(pos, b);
            msg_len_bytes = msg_len_bytes + 61'd1;
            if (pos == POS_LAST) begin
                compress_block_words();
            end
        end
        if (last) begin
            pos = msg_len_bytes[5:0];
            place_byte(pos, PAD_BYTE);
            for (int i = int'(pos[5:2]) + 1; i < 16; i++) begin
                msg_block[i] = '0;
            end
            // no room for the length field: spill into an extra block
            if (pos >= 6'd56) begin
                compress_block_words();
                foreach (msg_block[i]) begin
                    msg_block[i] = '0;
                end
            end
            bit_len = {msg_len_bytes, 3'b000};
            msg_block[14] = bit_len[63:32];
            msg_block[15] = bit_len[31:0];
            compress_block_words();
            for (int i = 0; i < 5; i++) begin
                pending_digest_words.push_back('{run_hash[i], 3'(i), (3'(i) == IDX_LAST)});
            end
            reload_initial_hash();
            msg_len_bytes = '0;
        end
    endfunction

    // ------------------------------------------------------------------
    // Stimulus building
    // ------------------------------------------------------------------
    task automatic queue_request(input logic [7:0] v, input logic p, input logic l,
                                 input logic hold);
        byte_requests.push_back('{v, p, l, hold});
        if (p || l) begin
            queued_items++;
        end
    endtask

    // A message of len random bytes, with stray no-byte requests mixed in.
    // The end flag rides on the final byte or comes as a separate no-byte request.
    task automatic queue_message(input int unsigned len, input logic hold);
        logic apart;
        logic hold_next;
        apart     = (len == 0) || ($urandom_range(0, 3) == 0);
        hold_next = hold;
        for (int unsigned n = 0; n < len; n++) begin
            if ($urandom_range(0, 15) == 0) begin
                queue_request(8'($urandom), 1'b0, 1'b0, hold_next);
                hold_next = 1'b0;
            end
            queue_request(8'($urandom), 1'b1, (n == len - 1) && !apart, hold_next);
            hold_next = 1'b0;
        end
        if (apart) begin
            queue_request(8'($urandom), 1'b0, 1'b1, hold_next);
        end
        messages++;
    endtask

    // ------------------------------------------------------------------
    // Driver: bursts of requests separated by random gaps
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid   <= 1'b0;
            gap_left  <= 0;
            burst_left <= 0;
        end else begin
            if (i_valid && o_ready) begin
                predict_request(i_byte_value, i_byte_present, i_is_last);
            end
            // slot is free unless a request is still waiting for o_ready
            if (!i_valid || o_ready) begin
                if (gap_left != 0) begin
                    gap_left <= gap_left - 1;
                    i_valid  <= 1'b0;
                end else if (byte_requests.size() != 0 &&
                             (!byte_requests[0].wait_drain ||
                              pending_digest_words.size() == 0)) begin
                    i_valid        <= 1'b1;
                    i_byte_value   <= byte_requests[0].value;
                    i_byte_present <= byte_requests[0].present;
                    i_is_last      <= byte_requests[0].last;
                    void'(byte_requests.pop_front());
                    if (burst_left == 0) begin
                        burst_left <= $urandom_range(1, 16);
                        // a quarter of the bursts run straight into the next one
                        gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
                    end else begin
                        burst_left <= burst_left - 1;
                    end
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Receiver stall pattern and digest word checker
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        // a new 8-bit pattern is drawn periodically and rotated; bit 0 is always set so a stall
        // never outlasts one rotation; a third of the patterns never stall
        if (ready_phase == 31) begin
            ready_phase <= 0;
            ready_bits  <= ($urandom_range(0, 2) == 0) ? 8'hFF : (8'($urandom) | 8'h01);
        end else begin
            ready_phase <= ready_phase + 1;
            ready_bits  <= {ready_bits[0], ready_bits[7:1]};
        end
        i_ready <= ready_bits[0];

        if (i_rst_n && o_valid && i_ready) begin
            if (pending_digest_words.size() == 0) begin
                $display("%0t: unexpected digest word %h index %0d", $time,
                         o_digest_word, o_word_index);
                mismatches++;
            end else begin
                want = pending_digest_words.pop_front();
                if (o_digest_word !== want.word) begin
                    $display("%0t: digest word expected %h actual %h", $time,
                             want.word, o_digest_word);
                    mismatches++;
                end
                if (o_word_index !== want.index) begin
                    $display("%0t: word index expected %0d actual %0d", $time,
                             want.index, o_word_index);
                    mismatches++;
                end
                if (o_last_word !== want.last) begin
                    $display("%0t: last word flag expected %b actual %b", $time,
                             want.last, o_last_word);
                    mismatches++;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Watchdog: no transfer on either side for too long means a hang
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IdleLimit) begin
            $display("%0t: no transfer for %0d cycles", $time, IdleLimit);
            $display("tb: failure");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        reload_initial_hash();
        foreach (msg_block[i]) begin
            msg_block[i] = '0;
        end
        msg_len_bytes = '0;

        // Directed: empty message, "abc", ignored no-byte request, single-byte
        // extremes, and a message closed by a last request without a byte.
        queue_request(8'h3C, 1'b0, 1'b1, 1'b0);
        queue_request(8'h61, 1'b1, 1'b0, 1'b0);
        queue_request(8'h62, 1'b1, 1'b0, 1'b0);
        queue_request(8'h63, 1'b1, 1'b1, 1'b0);
        queue_request(8'hFF, 1'b0, 1'b0, 1'b0);
        queue_request(8'h00, 1'b1, 1'b1, 1'b0);
        queue_request(8'hFF, 1'b1, 1'b1, 1'b0);
        queue_request(8'hA5, 1'b1, 1'b0, 1'b0);
        queue_request(8'h00, 1'b0, 1'b0, 1'b0);
        queue_request(8'h5A, 1'b1, 1'b0, 1'b0);
        queue_request(8'hFF, 1'b0, 1'b1, 1'b0);

        // Random: first a length that needs the spill block (held until the
        // directed digests are all out), then one that fills a whole block,
        // then a few short messages.
        queued_items = 0;
        messages     = 0;
        queue_message(56, 1'b1);
        queue_message(64, 1'b0);
        while (queued_items < 124 || messages < 3) begin
            pick = $urandom_range(0, 12);
            queue_message(pick, $urandom_range(0, 5) == 0);
        end

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // wait for every request to go in and every digest to come out
        while (byte_requests.size() != 0 || i_valid || pending_digest_words.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DrainCycles) @(posedge i_clk);

        if (pending_digest_words.size() != 0) begin
            $display("%0t: %0d digest words never arrived", $time,
                     pending_digest_words.size());
            mismatches++;
        end
        if (mismatches == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
src/sha1_pkg.sv
src/sha1_round.sv
src/sha1_message_digest_core.sv
src/sha1_chk.sv
sim/tb_top.sv
